// ===== rtl/upd_pkg.sv =====
package upd_pkg;

    // Result status codes
    localparam logic [2:0] ST_BYTE = 3'd0;
    localparam logic [2:0] ST_PEND = 3'd1;
    localparam logic [2:0] ST_DONE = 3'd2;
    localparam logic [2:0] ST_ERR  = 3'd3;
    localparam logic [2:0] ST_IGN  = 3'd4;

    // Configuration register indexes
    localparam logic REG_BUFFER_SIZE = 1'b0;

    localparam int unsigned BUF_SIZE_W = 11;
    localparam int unsigned COUNT_W    = 10;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 11'd128;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_MAX   = 11'd1024;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_   = 8'h66;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         out_byte;
        logic [COUNT_W-1:0] out_count;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[CH_0:CH_9]}) begin
            v = c - CH_0;
            return {1'b1, v[3:0]};
        end else if (c inside {[CH_LA:CH_LF_]}) begin
            v = c - CH_LA + HEX_ALPHA_OFS;
            return {1'b1, v[3:0]};
        end else if (c inside {[CH_UA:CH_UF]}) begin
            v = c - CH_UA + HEX_ALPHA_OFS;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        return c inside {CH_NUL, CH_CR, CH_LF, CH_TAB, CH_SPACE, CH_QMARK};
    endfunction

    function automatic logic is_allowed_literal(input logic [7:0] c);
        return c inside {[CH_0:CH_9], [CH_LA:CH_LZ], [CH_UA:CH_UZ],
                         CH_UNDER, CH_MINUS, CH_PLUS, CH_SLASH};
    endfunction

endpackage

// ===== rtl/upd_decode.sv =====
module upd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_url_byte,
    input  logic                          i_first_flag,
    input  logic [upd_pkg::BUF_SIZE_W-1:0] i_buffer_size,
    output upd_pkg::t_result              o_result
);
    import upd_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_HI,
        MODE_LO
    } t_mode;

    t_mode               r_mode, n_mode, e_mode;
    logic [3:0]          r_nibble, n_nibble, e_nibble;
    logic [COUNT_W-1:0]  r_count, n_count, e_count;
    logic                r_dot, n_dot, e_dot;
    logic [BUF_SIZE_W-1:0] lim;
    logic                full;
    logic [4:0]          hex;
    logic [2:0]          status;
    logic [7:0]          dbyte;

    always_comb begin
        // a first flag restarts the path before this byte is looked at
        if (i_first_flag) begin
            e_mode   = MODE_LIT;
            e_nibble = 4'd0;
            e_count  = '0;
            e_dot    = 1'b0;
        end else begin
            e_mode   = r_mode;
            e_nibble = r_nibble;
            e_count  = r_count;
            e_dot    = r_dot;
        end

        lim  = (i_buffer_size > BUF_SIZE_MAX) ? BUF_SIZE_MAX : i_buffer_size;
        full = ({1'b0, e_count} + BUF_SIZE_W'(1)) >= lim;
        hex  = hex_value(i_url_byte);

        n_mode   = e_mode;
        n_nibble = e_nibble;
        n_count  = e_count;
        n_dot    = e_dot;
        status   = ST_IGN;
        dbyte    = 8'd0;

        case (e_mode)
            MODE_LIT: begin
                if (is_terminator(i_url_byte)) begin
                    status = ST_DONE;
                end else if (full) begin
                    status = ST_ERR;
                end else if (i_url_byte == CH_DOT) begin
                    if (e_dot) begin
                        status = ST_ERR;
                    end else begin
                        status = ST_BYTE;
                        dbyte  = i_url_byte;
                        n_dot  = 1'b1;
                    end
                end else if (i_url_byte == CH_PCT) begin
                    status = ST_PEND;
                    n_mode = MODE_HI;
                end else if (is_allowed_literal(i_url_byte)) begin
                    status = ST_BYTE;
                    dbyte  = i_url_byte;
                    n_dot  = 1'b0;
                end else begin
                    status = ST_ERR;
                end
            end
            MODE_HI: begin
                if (!hex[4]) begin
                    status = ST_ERR;
                end else begin
                    status   = ST_PEND;
                    n_nibble = hex[3:0];
                    n_mode   = MODE_LO;
                end
            end
            MODE_LO: begin
                if (!hex[4]) begin
                    status = ST_ERR;
                end else begin
                    status = ST_BYTE;
                    dbyte  = {e_nibble, hex[3:0]};
                    n_dot  = 1'b0;
                    n_mode = MODE_LIT;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                status = ST_IGN;
            end
        endcase

        if (status == ST_BYTE) begin
            n_count = e_count + COUNT_W'(1);
        end else if (status == ST_DONE || status == ST_ERR) begin
            n_mode = MODE_IDLE;
        end

        o_result.status    = status;
        o_result.out_byte  = dbyte;
        o_result.out_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_nibble <= 4'd0;
            r_count  <= '0;
            r_dot    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
            r_count  <= n_count;
            r_dot    <= n_dot;
        end
    end

endmodule

// ===== rtl/upd_out_buf.sv =====
module upd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  upd_pkg::t_result i_result,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output upd_pkg::t_result o_result
);
    import upd_pkg::*;

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    pop;

    assign pop      = r_main_v && i_ready;
    assign o_space  = !r_skid_v;
    assign o_valid  = r_main_v;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // refill the output stage from the skid entry
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_load) begin
            if (r_main_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end else if (pop) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_load) begin
            if (r_main_v && !pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule

// ===== rtl/url_path_percent_decoder_unit.sv =====
// A result is valid the cycle after its byte transfer (one register stage), or waits
// in the skid entry behind a held result. Throughput: one byte per cycle while
// o_ready is high; decode state and result register update in the accepting cycle,
// and a two-entry output buffer keeps o_ready high for one stalled result.
// Reset: synchronous, active low; decoder waits for a first flag, buffer_size = 128.
module url_path_percent_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_url_byte,
    input  logic        i_first_flag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_byte,
    output logic [9:0]  o_out_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import upd_pkg::*;

    logic [BUF_SIZE_W-1:0] r_buffer_size;
    logic    accept;
    logic    cfg_wr;
    t_result dec_result, out_result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_SIZE_RESET;
        end else if (cfg_wr && paddr[2] == REG_BUFFER_SIZE) begin
            r_buffer_size <= pwdata[BUF_SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_BUFFER_SIZE) begin
            prdata = {{(32-BUF_SIZE_W){1'b0}}, r_buffer_size};
        end
    end

    upd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_url_byte   (i_url_byte),
        .i_first_flag (i_first_flag),
        .i_buffer_size(r_buffer_size),
        .o_result     (dec_result)
    );

    upd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_result(dec_result),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(out_result)
    );

    assign o_status    = out_result.status;
    assign o_out_byte  = out_result.out_byte;
    assign o_out_count = out_result.out_count;

    // the buffer only fills its skid entry behind a held result
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    a_transfer_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted byte produced no result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_IGN)
        else $error("status code out of range");

    a_byte_only_when_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_BYTE) |-> o_out_byte == 8'd0)
        else $error("data byte set on a non-byte result");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == REG_BUFFER_SIZE) |=>
            r_buffer_size == $past(pwdata[BUF_SIZE_W-1:0]))
        else $error("buffer_size write lost");

endmodule

// ===== tb/url_path_percent_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module url_path_percent_decoder_unit_test;
    import upd_pkg::*;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_LIT,
        DEC_HI,
        DEC_LO
    } dec_mode_e;

    localparam logic [2:0] BUF_SIZE_ADDR = {REG_BUFFER_SIZE, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_url_byte = 8'd0;
    logic        i_first_flag = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_out_byte;
    logic [9:0]  o_out_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // decoder shadow state
    dec_mode_e             dec_mode = DEC_IDLE;
    logic [3:0]            dec_high_nib = 4'd0;
    logic [COUNT_W-1:0]    dec_count = '0;
    logic                  dec_after_dot = 1'b0;
    logic [BUF_SIZE_W-1:0] dec_buf_size = BUF_SIZE_RESET;

    t_result pending_decodes[$];
    int      mismatch_count = 0;
    int      live_items = 0;
    bit      tx_idle_en = 1'b1;
    bit      rx_idle_en = 1'b1;
    int      ready_hold = 0;

    url_path_percent_decoder_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_url_byte   (i_url_byte),
        .i_first_flag (i_first_flag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_out_byte   (o_out_byte),
        .o_out_count  (o_out_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF_) begin
            d = c - CH_LA + HEX_ALPHA_OFS;
            return {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + HEX_ALPHA_OFS;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // Advance the shadow decoder by one byte and return the result it gives.
    function automatic t_result decode_byte(input logic [7:0] c, input logic lead);
        t_result               r;
        logic [4:0]            nib;
        logic [BUF_SIZE_W-1:0] lim;
        logic                  path_end;
        logic                  plain;
        logic                  full;
        r.status    = ST_IGN;
        r.out_byte  = 8'd0;
        r.out_count = '0;
        if (lead) begin
            dec_mode      = DEC_LIT;
            dec_high_nib  = 4'd0;
            dec_count     = '0;
            dec_after_dot = 1'b0;
        end
        lim = (dec_buf_size > BUF_SIZE_MAX) ? BUF_SIZE_MAX : dec_buf_size;
        full = ({1'b0, dec_count} + 11'd1) >= lim;
        path_end = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) ||
                   (c == CH_SPACE) || (c == CH_QMARK);
        plain = (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
                (c >= CH_UA && c <= CH_UZ) || (c == CH_UNDER) || (c == CH_MINUS) ||
                (c == CH_PLUS) || (c == CH_SLASH);
        case (dec_mode)
            DEC_LIT: begin
                if (path_end) begin
                    r.status = ST_DONE;
                end else if (full) begin
                    r.status = ST_ERR;
                end else if (c == CH_DOT) begin
                    if (dec_after_dot) begin
                        r.status = ST_ERR;
                    end else begin
                        r.status      = ST_BYTE;
                        r.out_byte    = c;
                        dec_after_dot = 1'b1;
                    end
                end else if (c == CH_PCT) begin
                    r.status = ST_PEND;
                    dec_mode = DEC_HI;
                end else if (plain) begin
                    r.status      = ST_BYTE;
                    r.out_byte    = c;
                    dec_after_dot = 1'b0;
                end else begin
                    r.status = ST_ERR;
                end
            end
            DEC_HI: begin
                nib = hex_nibble(c);
                if (!nib[4]) begin
                    r.status = ST_ERR;
                end else begin
                    dec_high_nib = nib[3:0];
                    r.status     = ST_PEND;
                    dec_mode     = DEC_LO;
                end
            end
            DEC_LO: begin
                nib = hex_nibble(c);
                if (!nib[4]) begin
                    r.status = ST_ERR;
                end else begin
                    r.status      = ST_BYTE;
                    r.out_byte    = {dec_high_nib, nib[3:0]};
                    dec_after_dot = 1'b0;
                    dec_mode      = DEC_LIT;
                end
            end
            default: begin
                dec_mode = DEC_IDLE;
            end
        endcase
        if (r.status == ST_BYTE) begin
            dec_count = dec_count + 1'b1;
        end else if (r.status == ST_DONE || r.status == ST_ERR) begin
            dec_mode = DEC_IDLE;
        end
        r.out_count = dec_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = decode_byte(i_url_byte, i_first_flag);
                if (want.status != ST_IGN) begin
                    live_items++;
                end
                pending_decodes.push_back(want);
            end
            if (o_valid && i_ready) begin
                got.status    = o_status;
                got.out_byte  = o_out_byte;
                got.out_count = o_out_count;
                if (pending_decodes.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result at %0t: status %0d byte %02h count %0d",
                                 $time, got.status, got.out_byte, got.out_count);
                    end
                    mismatch_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    if (got.status !== want.status || got.out_byte !== want.out_byte ||
                        got.out_count !== want.out_count) begin
                        if (mismatch_count < 10) begin
                            $display({"mismatch at %0t: status exp %0d got %0d, ",
                                      "byte exp %02h got %02h, count exp %0d got %0d"},
                                     $time, want.status, got.status, want.out_byte,
                                     got.out_byte, want.out_count, got.out_count);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Result side backpressure: i_ready drops in random bursts while rx_idle_en is set.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 4);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Returns at the edge of the transfer with valid still high.
    task automatic send_byte(input logic [7:0] c, input logic lead);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_url_byte   <= c;
        i_first_flag <= lead;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], k == 0);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        // let the checker record the last transfer before looking at the queue
        @(posedge i_clk);
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_buffer_size(input logic [BUF_SIZE_W-1:0] size);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUF_SIZE_ADDR;
        pwdata  <= {{(32 - BUF_SIZE_W){1'b0}}, size};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dec_buf_size = size;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(32 - BUF_SIZE_W){1'b0}}, size}) begin
            if (mismatch_count < 10) begin
                $display("buffer_size readback at %0t: exp %0d got %0d", $time, size, prdata);
            end
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] k;
        logic [7:0] c;
        k = $urandom_range(0, 25);
        case ($urandom_range(0, 3))
            0: c = CH_0 + (k % 10);
            1: c = CH_LA + k;
            2: c = CH_UA + k;
            default: begin
                case (k % 4)
                    0: c = CH_UNDER;
                    1: c = CH_MINUS;
                    2: c = CH_PLUS;
                    default: c = CH_SLASH;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] n;
        n = $urandom_range(0, 15);
        if (n < 10) begin
            return CH_0 + n;
        end
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + n - HEX_ALPHA_OFS;
    endfunction

    task automatic send_random_path(input int max_len, input bit noisy);
        logic [7:0] path_q[$];
        int         len;
        int         r;
        len = $urandom_range(1, max_len);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                path_q.push_back(rand_plain());
            end else if (r < 67) begin
                // keep clean paths free of double dots
                if (!noisy && path_q.size() != 0 && path_q[$] == CH_DOT) begin
                    path_q.push_back(rand_plain());
                end else begin
                    path_q.push_back(CH_DOT);
                end
            end else if (r < 85) begin
                path_q.push_back(CH_PCT);
                path_q.push_back(rand_hex_char());
                path_q.push_back(rand_hex_char());
            end else if (noisy && r < 92) begin
                path_q.push_back($urandom_range(0, 255));
            end else if (noisy && r < 97) begin
                path_q.push_back(CH_PCT);
                if ($urandom_range(0, 1)) begin
                    path_q.push_back(rand_hex_char());
                end
                path_q.push_back($urandom_range(0, 255));
            end else begin
                path_q.push_back(rand_plain());
            end
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            case ($urandom_range(0, 5))
                0: path_q.push_back(CH_NUL);
                1: path_q.push_back(CH_TAB);
                2: path_q.push_back(CH_LF);
                3: path_q.push_back(CH_CR);
                4: path_q.push_back(CH_SPACE);
                default: path_q.push_back(CH_QMARK);
            endcase
            // trailing bytes after the end are ignored by the block (status ST_IGN)
            if (r >= 70) begin
                path_q.push_back($urandom_range(0, 255));
            end
        end
        foreach (path_q[k]) begin
            send_byte(path_q[k], k == 0);
        end
    endtask

    task automatic run_random_phase(input logic [BUF_SIZE_W-1:0] size, input int max_len,
                                    input int n_items);
        int base;
        set_buffer_size(size);
        base = live_items;
        while (live_items - base < n_items) begin
            send_random_path(max_len, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 40) == 0) begin
                wait_for_results();
            end
        end
    endtask

    task automatic test_idle_after_reset();
        send_byte(CH_LA, 1'b0);
        send_byte(CH_PCT, 1'b0);
        send_byte(CH_NUL, 1'b0);
    endtask

    task automatic test_directed_paths();
        send_text("/Az9_-+.%2e.%Ff?");
        send_byte(CH_SPACE, 1'b0);
        send_text("..");
        send_byte(CH_PCT, 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b1);
        // restart in the middle of an escape
        send_text("%4");
        send_text("q");
        send_byte(CH_NUL, 1'b1);
    endtask

    task automatic test_buffer_limits();
        logic [7:0] path_q[$];
        int         made;
        set_buffer_size(1);
        send_text("a");
        send_text("?");
        send_text("%");
        set_buffer_size(0);
        send_text("Z");
        send_byte(CH_NUL, 1'b1);
        set_buffer_size(2);
        send_text("ab");
        send_text("%41%");
        send_text(".");
        // above the maximum: clamps to 1024, so 1023 bytes fit
        set_buffer_size({BUF_SIZE_W{1'b1}});
        made = 0;
        while (made < 1023) begin
            if ($urandom_range(0, 15) == 0) begin
                path_q.push_back(CH_PCT);
                path_q.push_back(rand_hex_char());
                path_q.push_back(rand_hex_char());
            end else if ($urandom_range(0, 7) == 0 && path_q.size() != 0 &&
                         path_q[$] != CH_DOT) begin
                path_q.push_back(CH_DOT);
            end else begin
                path_q.push_back(rand_plain());
            end
            made++;
        end
        path_q.push_back(CH_LA);
        path_q.push_back(CH_QMARK);
        foreach (path_q[k]) begin
            send_byte(path_q[k], k == 0);
        end
        set_buffer_size(BUF_SIZE_MAX);
        send_text("ok/path?");
    endtask

    task automatic test_random_traffic();
        run_random_phase(16, 20, 80);
        run_random_phase(BUF_SIZE_MAX, 24, 80);
        run_random_phase($urandom_range(2, 6), 10, 60);
        // final stretch runs at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_phase(64, 30, 80);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_directed_paths();
        test_buffer_limits();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
